/* sv/rusi_pkg.sv */
// ----------------------------------------------------------------------------
// rusi_pkg: shared types and constants for the ray / unit sphere intersector
// Request structs, lane structs for the square root and divider chains,
// and the widths of the exact integer datapath.
// ----------------------------------------------------------------------------
package rusi_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned DEF_FRAC_BITS = 16;
  // single 32x32 product and the sums of three of them
  localparam int unsigned PROD_W        = 64;
  localparam int unsigned SUM_W         = 66;
  // discriminant, its root and the root remainder
  localparam int unsigned DISC_W        = 128;
  localparam int unsigned ROOT_W        = 64;
  localparam int unsigned REM_W         = 66;
  localparam int unsigned SQ_STEPS      = 64;
  // -H +/- S before the fraction shift
  localparam int unsigned NUM_W         = 67;
  // quotient bits developed by the divider; above this the result saturates
  localparam int unsigned QUO_W         = 33;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic        [TAG_W-1:0]   object_tag;
  } in_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] t_near;
    logic signed [COORD_W-1:0] t_far;
    logic        [TAG_W-1:0]   hit_object;
  } out_req_t;

  // values that ride beside the square root chain
  typedef struct packed {
    logic                    hit;
    logic [PROD_W-1:0]       a;
    logic signed [SUM_W-1:0] h;
    logic [TAG_W-1:0]        tag;
  } side_t;

  // values that ride beside the divider chains
  typedef struct packed {
    logic              hit;
    logic [PROD_W-1:0] a;
    logic [TAG_W-1:0]  tag;
  } post_side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [DISC_W-1:0] rad;
  } sqrt_lane_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  low;
    logic              neg;
    logic              big;
  } div_lane_t;

  function automatic logic signed [SUM_W-1:0] sx_prod(input logic signed [PROD_W-1:0] v);
    sx_prod = {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

endpackage

/* sv/ray_unit_sphere_intersect.sv */
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect: ray against the unit sphere at the origin
// Throughput: one request per cycle; the 64-cell square root chain and the
// two 33-cell divider chains each take a new request every cycle.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears the valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module ray_unit_sphere_intersect #(
  parameter int unsigned FRAC_BITS = rusi_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rusi_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output rusi_pkg::out_req_t  out_req
);
  import rusi_pkg::*;

  localparam int unsigned MAG_W = NUM_W + FRAC_BITS;

  logic en;

  logic              q_v;
  side_t             q_side;
  logic [DISC_W-1:0] q_disc;

  sqrt_lane_t        sq_lane [SQ_STEPS+1];
  side_t             sq_side_r [SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_v_r;

  logic signed [NUM_W-1:0] near1_r, far1_r;
  post_side_t              side1_r;
  logic [MAG_W-1:0]        mnear2_r, mfar2_r;
  logic                    nneg2_r, fneg2_r;
  post_side_t              side2_r;
  logic [2:0]              t_v_r;

  logic [MAG_W-1:0]  near_hi, far_hi;
  div_lane_t         dn_lane [QUO_W+1];
  div_lane_t         df_lane [QUO_W+1];
  post_side_t        dv_side_r [QUO_W+1];
  logic [QUO_W-1:0]  dv_v_r;

  logic              out_valid_r;
  out_req_t          out_req_r;

  // hold everything while a finished result is not taken
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  rusi_quad #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quad (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .out_valid (q_v),
    .out_side  (q_side),
    .out_disc  (q_disc)
  );

  // square root chain, one root bit per cell
  assign sq_lane[0].rem  = '0;
  assign sq_lane[0].root = '0;
  assign sq_lane[0].rad  = q_disc;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    rusi_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .lane_in  (sq_lane[k]),
      .lane_out (sq_lane[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        sq_side_r[k] <= (k == 0) ? q_side : sq_side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // advance valid bits through all chains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r      <= '0;
      t_v_r       <= '0;
      dv_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      sq_v_r      <= {sq_v_r[SQ_STEPS-2:0], q_v};
      t_v_r       <= {t_v_r[1:0], sq_v_r[SQ_STEPS-1]};
      dv_v_r      <= {dv_v_r[QUO_W-2:0], t_v_r[2]};
      out_valid_r <= dv_v_r[QUO_W-1];
    end
  end

  // form -H - S and -H + S
  always_ff @(posedge clk) begin
    if (en) begin
      near1_r     <= -NUM_W'(sq_side_r[SQ_STEPS-1].h)
                     - NUM_W'(sq_lane[SQ_STEPS].root);
      far1_r      <= -NUM_W'(sq_side_r[SQ_STEPS-1].h)
                     + NUM_W'(sq_lane[SQ_STEPS].root);
      side1_r.hit <= sq_side_r[SQ_STEPS-1].hit;
      side1_r.a   <= sq_side_r[SQ_STEPS-1].a;
      side1_r.tag <= sq_side_r[SQ_STEPS-1].tag;
    end
  end

  // take magnitudes and scale by the fraction bits
  always_ff @(posedge clk) begin
    if (en) begin
      nneg2_r  <= near1_r[NUM_W-1];
      fneg2_r  <= far1_r[NUM_W-1];
      mnear2_r <= MAG_W'(near1_r[NUM_W-1] ? -near1_r : near1_r) << FRAC_BITS;
      mfar2_r  <= MAG_W'(far1_r[NUM_W-1] ? -far1_r : far1_r) << FRAC_BITS;
      side2_r  <= side1_r;
    end
  end

  // load the dividers; a quotient of 2^QUO_W or more only saturates
  assign near_hi = mnear2_r >> QUO_W;
  assign far_hi  = mfar2_r >> QUO_W;

  always_ff @(posedge clk) begin
    if (en) begin
      dn_lane[0].rem <= near_hi[PROD_W-1:0];
      dn_lane[0].quo <= '0;
      dn_lane[0].low <= mnear2_r[QUO_W-1:0];
      dn_lane[0].neg <= nneg2_r;
      dn_lane[0].big <= (near_hi >= MAG_W'(side2_r.a));
      df_lane[0].rem <= far_hi[PROD_W-1:0];
      df_lane[0].quo <= '0;
      df_lane[0].low <= mfar2_r[QUO_W-1:0];
      df_lane[0].neg <= fneg2_r;
      df_lane[0].big <= (far_hi >= MAG_W'(side2_r.a));
      dv_side_r[0]   <= side2_r;
    end
  end

  // divider chains for both roots, one quotient bit per cell
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rusi_div_cell u_near (
      .clk      (clk),
      .en       (en),
      .divisor  (dv_side_r[k].a),
      .lane_in  (dn_lane[k]),
      .lane_out (dn_lane[k+1])
    );

    rusi_div_cell u_far (
      .clk      (clk),
      .en       (en),
      .divisor  (dv_side_r[k].a),
      .lane_in  (df_lane[k]),
      .lane_out (df_lane[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  // floor and saturate one quotient to a signed result
  function automatic logic [COORD_W-1:0] sat_root(input div_lane_t l);
    logic [QUO_W:0] qq;
    qq = {1'b0, l.quo} + {{QUO_W{1'b0}}, (l.rem != '0)};
    if (!l.neg) begin
      if (l.big || (l.quo > QUO_W'({1'b0, {(COORD_W-1){1'b1}}}))) begin
        sat_root = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        sat_root = l.quo[COORD_W-1:0];
      end
    end else begin
      if (l.big || (qq > (QUO_W+1)'({1'b1, {(COORD_W-1){1'b0}}}))) begin
        sat_root = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        sat_root = COORD_W'(-qq);
      end
    end
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_req_r.hit        <= dv_side_r[QUO_W].hit;
      out_req_r.t_near     <= dv_side_r[QUO_W].hit ? sat_root(dn_lane[QUO_W]) : '0;
      out_req_r.t_far      <= dv_side_r[QUO_W].hit ? sat_root(df_lane[QUO_W]) : '0;
      out_req_r.hit_object <= dv_side_r[QUO_W].tag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

/* sv/rusi_quad.sv */
// ----------------------------------------------------------------------------
// rusi_quad: quadratic coefficients and discriminant
// Six pipeline stages: component products, dot products, magnitudes,
// 32x32 partial products, product assembly and the discriminant test.
// ----------------------------------------------------------------------------
module rusi_quad #(
  parameter int unsigned FRAC_BITS = rusi_pkg::DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  rusi_pkg::in_req_t            in_req,
  output logic                         out_valid,
  output rusi_pkg::side_t              out_side,
  output logic [rusi_pkg::DISC_W-1:0]  out_disc
);
  import rusi_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE_SQ = SUM_W'(1) << (2 * FRAC_BITS);

  logic [5:0] v_r;

  logic signed [PROD_W-1:0] dd_r [3];
  logic signed [PROD_W-1:0] dp_r [3];
  logic signed [PROD_W-1:0] oo_r [3];
  logic [TAG_W-1:0]         tag1_r;

  logic [PROD_W-1:0]       a2_r;
  logic signed [SUM_W-1:0] h2_r;
  logic signed [SUM_W-1:0] c2_r;
  logic [TAG_W-1:0]        tag2_r;

  logic [PROD_W-1:0] hmag_r, cmag_r;
  logic              cneg3_r;
  side_t             side3_r;

  logic [PROD_W-1:0] hh0_r, hh1_r, hh3_r;
  logic [PROD_W-1:0] ac0_r, ac1_r, ac2_r, ac3_r;
  logic              cneg4_r;
  side_t             side4_r;

  logic [DISC_W-1:0] hsq_r, ac_r;
  logic              cneg5_r;
  side_t             side5_r;

  logic [DISC_W-1:0] disc_r;
  side_t             side6_r;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  // stage 1: component products
  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0] <= in_req.dir_x * in_req.dir_x;
      dd_r[1] <= in_req.dir_y * in_req.dir_y;
      dd_r[2] <= in_req.dir_z * in_req.dir_z;
      dp_r[0] <= in_req.dir_x * in_req.origin_x;
      dp_r[1] <= in_req.dir_y * in_req.origin_y;
      dp_r[2] <= in_req.dir_z * in_req.origin_z;
      oo_r[0] <= in_req.origin_x * in_req.origin_x;
      oo_r[1] <= in_req.origin_y * in_req.origin_y;
      oo_r[2] <= in_req.origin_z * in_req.origin_z;
      tag1_r  <= in_req.object_tag;
    end
  end

  // stage 2: dot products; squares are non-negative so A stays unsigned
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r   <= PROD_W'(dd_r[0]) + PROD_W'(dd_r[1]) + PROD_W'(dd_r[2]);
      h2_r   <= sx_prod(dp_r[0]) + sx_prod(dp_r[1]) + sx_prod(dp_r[2]);
      c2_r   <= sx_prod(oo_r[0]) + sx_prod(oo_r[1]) + sx_prod(oo_r[2]) - ONE_SQ;
      tag2_r <= tag1_r;
    end
  end

  // stage 3: magnitudes of H and C
  always_ff @(posedge clk) begin
    if (en) begin
      hmag_r      <= h2_r[SUM_W-1] ? PROD_W'(-h2_r) : h2_r[PROD_W-1:0];
      cmag_r      <= c2_r[SUM_W-1] ? PROD_W'(-c2_r) : c2_r[PROD_W-1:0];
      cneg3_r     <= c2_r[SUM_W-1];
      side3_r.hit <= 1'b0;
      side3_r.a   <= a2_r;
      side3_r.h   <= h2_r;
      side3_r.tag <= tag2_r;
    end
  end

  // stage 4: 32x32 partial products of H*H and A*|C|
  always_ff @(posedge clk) begin
    if (en) begin
      hh0_r   <= hmag_r[31:0]  * hmag_r[31:0];
      hh1_r   <= hmag_r[31:0]  * hmag_r[63:32];
      hh3_r   <= hmag_r[63:32] * hmag_r[63:32];
      ac0_r   <= side3_r.a[31:0]  * cmag_r[31:0];
      ac1_r   <= side3_r.a[31:0]  * cmag_r[63:32];
      ac2_r   <= side3_r.a[63:32] * cmag_r[31:0];
      ac3_r   <= side3_r.a[63:32] * cmag_r[63:32];
      cneg4_r <= cneg3_r;
      side4_r <= side3_r;
    end
  end

  // stage 5: assemble the full products
  always_ff @(posedge clk) begin
    if (en) begin
      hsq_r   <= {hh3_r, hh0_r} + ({64'd0, hh1_r} << 33);
      ac_r    <= {ac3_r, ac0_r} + ({64'd0, ac1_r} << 32) + ({64'd0, ac2_r} << 32);
      cneg5_r <= cneg4_r;
      side5_r <= side4_r;
    end
  end

  // stage 6: discriminant, hit needs it non-negative and a non-zero direction
  always_ff @(posedge clk) begin
    if (en) begin
      disc_r      <= cneg5_r ? (hsq_r + ac_r) : (hsq_r - ac_r);
      side6_r.hit <= (cneg5_r || (hsq_r >= ac_r)) && (side5_r.a != '0);
      side6_r.a   <= side5_r.a;
      side6_r.h   <= side5_r.h;
      side6_r.tag <= side5_r.tag;
    end
  end

  assign out_valid = v_r[5];
  assign out_side  = side6_r;
  assign out_disc  = disc_r;

endmodule

/* sv/rusi_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rusi_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, trial-subtracts 4q+1 and yields one root bit.
// ----------------------------------------------------------------------------
module rusi_sqrt_cell (
  input  logic                  clk,
  input  logic                  en,
  input  rusi_pkg::sqrt_lane_t  lane_in,
  output rusi_pkg::sqrt_lane_t  lane_out
);
  import rusi_pkg::*;

  localparam int unsigned CUR_W = REM_W + 2;

  logic [CUR_W-1:0] cur;
  logic [CUR_W-1:0] trial;
  logic             take;
  sqrt_lane_t       lane_r;

  // form the partial remainder and the trial value
  assign cur   = {lane_in.rem, lane_in.rad[DISC_W-1 -: 2]};
  assign trial = CUR_W'({lane_in.root, 2'b01});
  assign take  = (cur >= trial);

  // hand the result to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r.rem  <= take ? REM_W'(cur - trial) : REM_W'(cur);
      lane_r.root <= {lane_in.root[ROOT_W-2:0], take};
      lane_r.rad  <= {lane_in.rad[DISC_W-3:0], 2'b00};
    end
  end

  assign lane_out = lane_r;

endmodule

/* sv/rusi_div_cell.sv */
// ----------------------------------------------------------------------------
// rusi_div_cell: one step of restoring division
// Brings down one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module rusi_div_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rusi_pkg::PROD_W-1:0]  divisor,
  input  rusi_pkg::div_lane_t          lane_in,
  output rusi_pkg::div_lane_t          lane_out
);
  import rusi_pkg::*;

  logic [PROD_W:0] cur;
  logic            take;
  div_lane_t       lane_r;

  // shift in the next bit and compare
  assign cur  = {lane_in.rem, lane_in.low[QUO_W-1]};
  assign take = (cur >= {1'b0, divisor});

  // hand the result to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r.rem <= take ? PROD_W'(cur - {1'b0, divisor}) : cur[PROD_W-1:0];
      lane_r.quo <= {lane_in.quo[QUO_W-2:0], take};
      lane_r.low <= {lane_in.low[QUO_W-2:0], 1'b0};
      lane_r.neg <= lane_in.neg;
      lane_r.big <= lane_in.big;
    end
  end

  assign lane_out = lane_r;

endmodule
